FILE: rtl/pdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the deframer.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam logic [15:0] HEADER_BYTES   = 16'd12;
    localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] BUF_SIZE_RESET = 16'hFFFF;
    localparam logic [7:0]  MAGIC_RESET    = 8'h00;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        CFG_MAGIC    = 1'b0,
        CFG_BUF_SIZE = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_PKT_LEN   = 3'd3,
        ST_BUF_LEN   = 3'd4,
        ST_CRC       = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [7:0]  version;
        logic [7:0]  packet_type;
        logic [7:0]  flags;
        logic [15:0] sequence_res;
        logic [15:0] meta;
        logic [15:0] payload_length;
    } t_out;

    typedef struct packed {
        logic first_vld;
        logic second_vld;
    } t_push;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pdc_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_result_fifo
// Small result queue: takes up to two beats per cycle, hands out one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pdc_result_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pdc_pkg::t_push i_push,
    input  wire pdc_pkg::t_out  i_first,
    input  wire pdc_pkg::t_out  i_second,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_stall,
    output pdc_pkg::t_out      o_data
);
    import pdc_pkg::*;

    t_out               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic [PTR_W-1:0]   w_wr_ptr_1;
    logic [COUNT_W-1:0] w_push_cnt;
    logic               w_pop;

    assign w_wr_ptr_1 = r_wr_ptr + PTR_W'(1);
    assign w_push_cnt = COUNT_W'(i_push.first_vld) + COUNT_W'(i_push.second_vld);
    assign w_pop      = o_valid && !i_stall;
    assign o_valid    = (r_count != '0);
    assign o_room     = (r_count <= COUNT_W'(FIFO_DEPTH - 2));
    assign o_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wr_ptr] <= i_first;
        end
        if (i_push.second_vld) begin
            r_mem[w_wr_ptr_1] <= i_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(w_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + w_push_cnt - COUNT_W'(w_pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/packet_deframer_crc16_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_deframer_crc16_core
// Packet deframer: magic check, 12-byte header parse, payload forward with
// CRC-16/MODBUS check and an end-of-packet status beat.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle. Each byte is parsed in the cycle
// it is accepted and its results (a payload beat, a status beat on the last
// byte, or both) are written into a four-entry result queue. With an empty
// queue the first result of a byte appears on the output in the cycle after
// its byte; a second result, the status beat of a last byte that also carries
// payload, follows once the first has been taken. The input stalls only while
// fewer than two queue entries are free, which happens only when the output
// side is stalled; with a free-running consumer the rate is one byte per
// cycle. Configuration is taken at any time through the write port and must
// only change while no packet is in progress.
module packet_deframer_crc16_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire pdc_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output pdc_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    import pdc_pkg::*;

    logic [7:0]  r_magic_value;
    logic [15:0] r_buf_size;

    logic [15:0] r_byte_count, n_byte_count;
    logic        r_magic_ok,   n_magic_ok;
    logic [7:0]  r_version,    n_version;
    logic [7:0]  r_type,       n_type;
    logic [7:0]  r_flags,      n_flags;
    logic [15:0] r_sequence,   n_sequence;
    logic [15:0] r_meta,       n_meta;
    logic [15:0] r_length,     n_length;
    logic [15:0] r_hdr_crc,    n_hdr_crc;
    logic [15:0] r_crc,        n_crc;

    logic        w_accept;
    logic        w_fwd;
    logic        w_room;
    logic [15:0] w_max_pl;
    logic [15:0] w_crc_final;
    t_status     w_status;
    logic        w_show;
    t_out        w_payload_beat;
    t_out        w_status_beat;
    t_out        w_first;
    t_push       w_push;
    logic [7:0]  w_byte;

    assign o_stall  = !w_room;
    assign w_accept = i_valid && !o_stall;
    assign w_byte   = i_data.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_value <= MAGIC_RESET;
            r_buf_size    <= BUF_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MAGIC:    r_magic_value <= i_cfg_data[7:0];
                CFG_BUF_SIZE: r_buf_size    <= i_cfg_data;
                default:      r_buf_size    <= r_buf_size;
            endcase
        end
    end

    always_comb begin
        n_magic_ok = r_magic_ok;
        n_version  = r_version;
        n_type     = r_type;
        n_flags    = r_flags;
        n_sequence = r_sequence;
        n_meta     = r_meta;
        n_length   = r_length;
        n_hdr_crc  = r_hdr_crc;
        n_crc      = r_crc;
        w_fwd      = 1'b0;
        case (r_byte_count)
            16'd0:  n_magic_ok = (w_byte == r_magic_value);
            16'd1:  n_version  = w_byte;
            16'd2:  n_type     = w_byte;
            16'd3:  n_flags    = w_byte;
            16'd4:  n_sequence = {r_sequence[15:8], w_byte};
            16'd5:  n_sequence = {w_byte, r_sequence[7:0]};
            16'd6:  n_meta     = {r_meta[15:8], w_byte};
            16'd7:  n_meta     = {w_byte, r_meta[7:0]};
            16'd8:  n_length   = {r_length[15:8], w_byte};
            16'd9:  n_length   = {w_byte, r_length[7:0]};
            16'd10: n_hdr_crc  = {r_hdr_crc[15:8], w_byte};
            16'd11: n_hdr_crc  = {w_byte, r_hdr_crc[7:0]};
            default: begin
                if (r_byte_count != BYTE_COUNT_MAX
                        && (r_byte_count - HEADER_BYTES) < r_length) begin
                    n_crc = crc16_byte(r_crc, w_byte);
                    w_fwd = r_magic_ok && (r_length <= r_buf_size);
                end
            end
        endcase
        n_byte_count = (r_byte_count == BYTE_COUNT_MAX) ? r_byte_count
                                                        : r_byte_count + 16'd1;
    end

    always_comb begin
        w_max_pl    = (n_byte_count <= HEADER_BYTES) ? 16'd0
                                                     : n_byte_count - HEADER_BYTES;
        w_crc_final = (n_length == 16'd0) ? 16'd0 : n_crc;
        if (n_byte_count < HEADER_BYTES) begin
            w_status = ST_SHORT;
        end else if (!n_magic_ok) begin
            w_status = ST_MAGIC;
        end else if (n_length > w_max_pl) begin
            w_status = ST_PKT_LEN;
        end else if (n_length > r_buf_size) begin
            w_status = ST_BUF_LEN;
        end else if (w_crc_final != n_hdr_crc) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
        w_show = (w_status != ST_SHORT) && (w_status != ST_MAGIC);

        w_payload_beat              = '0;
        w_payload_beat.kind         = KIND_PAYLOAD;
        w_payload_beat.payload_byte = w_byte;
        w_payload_beat.status       = ST_OK;

        w_status_beat                = '0;
        w_status_beat.kind           = KIND_STATUS;
        w_status_beat.status         = w_status;
        if (w_show) begin
            w_status_beat.version        = n_version;
            w_status_beat.packet_type    = n_type;
            w_status_beat.flags          = n_flags;
            w_status_beat.sequence_res   = n_sequence;
            w_status_beat.meta           = n_meta;
            w_status_beat.payload_length = n_length;
        end

        w_first           = w_fwd ? w_payload_beat : w_status_beat;
        w_push.first_vld  = w_accept && (w_fwd || i_data.last_byte);
        w_push.second_vld = w_accept && w_fwd && i_data.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_data.last_byte)) begin
            r_byte_count <= '0;
            r_magic_ok   <= 1'b0;
            r_version    <= '0;
            r_type       <= '0;
            r_flags      <= '0;
            r_sequence   <= '0;
            r_meta       <= '0;
            r_length     <= '0;
            r_hdr_crc    <= '0;
            r_crc        <= CRC_INIT;
        end else if (w_accept) begin
            r_byte_count <= n_byte_count;
            r_magic_ok   <= n_magic_ok;
            r_version    <= n_version;
            r_type       <= n_type;
            r_flags      <= n_flags;
            r_sequence   <= n_sequence;
            r_meta       <= n_meta;
            r_length     <= n_length;
            r_hdr_crc    <= n_hdr_crc;
            r_crc        <= n_crc;
        end
    end

    pdc_result_fifo u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_first  (w_first),
        .i_second (w_status_beat),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.last_byte) |=> (r_byte_count == 16'd0 && r_crc == CRC_INIT))
        else $error("packet state not cleared after last byte");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == KIND_PAYLOAD)
            |-> (o_data.status == ST_OK && o_data.payload_length == 16'd0))
        else $error("payload beat carries status fields");

    a_fwd_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fwd |-> (r_byte_count >= HEADER_BYTES && r_magic_ok))
        else $error("forward outside payload region");

    a_hidden_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == KIND_STATUS
            && (o_data.status == ST_SHORT || o_data.status == ST_MAGIC))
            |-> (o_data.payload_length == 16'd0 && o_data.version == 8'd0))
        else $error("header shown on short or bad-magic packet");
`endif

endmodule
`default_nettype wire
